[src/rtp_header_parse_payload_strip_core_assert.svh]
// ---------------------------------------------------------------------------
// RTP header parser assertion macros
// Shared concurrent assertion forms for the parser and output queue.
// ---------------------------------------------------------------------------
`ifndef RTP_HEADER_PARSE_PAYLOAD_STRIP_CORE_ASSERT_SVH
`define RTP_HEADER_PARSE_PAYLOAD_STRIP_CORE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define RHP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rhp assertion failed");

// next-cycle implication, disabled in reset
`define RHP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rhp assertion failed");

`endif

[src/rhp_pkg.sv]
// ---------------------------------------------------------------------------
// rhp_pkg
// Result type, status codes and queue sizing for the RTP header parser.
// ---------------------------------------------------------------------------
`default_nettype none

package rhp_pkg;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_SHORT    = 3'd1;
    localparam logic [2:0] ST_CSRC     = 3'd2;
    localparam logic [2:0] ST_EXT_HDR  = 3'd3;
    localparam logic [2:0] ST_EXT_BODY = 3'd4;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 136;

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic        last;
        logic [2:0]  status;
        logic        marker;
        logic [6:0]  payload_type;
        logic [15:0] sequence_res;
        logic [31:0] timestamp;
        logic [31:0] ssrc;
        logic [1:0]  version;
        logic [15:0] payload_len;
        logic [15:0] ext_profile;
    } t_result;

    // up to two results per input word: payload byte then summary
    typedef struct packed {
        logic    pay_valid;
        logic    sum_valid;
        t_result pay;
        t_result sum;
    } t_push;

endpackage

`default_nettype wire

[src/rhp_parse.sv]
// ---------------------------------------------------------------------------
// rhp_parse
// Per-byte header field capture, skip counting and result generation.
// ---------------------------------------------------------------------------
`default_nettype none
`include "rtp_header_parse_payload_strip_core_assert.svh"

module rhp_parse #(
    parameter int MAX_PACKET_BYTES = 65535
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_valid,
    input  wire [7:0]      i_byte,
    input  wire            i_eop,
    output rhp_pkg::t_push o_push
);
    import rhp_pkg::*;

    typedef enum logic [2:0] {
        PH_FIXED,
        PH_CSRC,
        PH_EXTHDR,
        PH_EXTBODY,
        PH_PAYLOAD
    } t_phase;

    localparam logic [4:0]  FIXED_END    = 5'd12;
    localparam logic [4:0]  EXT_TYPE_END = 5'd14;
    localparam logic [4:0]  EXT_HDR_END  = 5'd16;
    localparam logic [15:0] MAX_BYTES    = 16'(MAX_PACKET_BYTES);

    t_phase      r_phase, n_phase;
    logic [15:0] r_byte_count, n_byte_count;
    logic [4:0]  r_hdr, n_hdr;
    logic [7:0]  r_flags, n_flags;
    logic [7:0]  r_mpt, n_mpt;
    logic [15:0] r_seq, n_seq;
    logic [31:0] r_ts, n_ts;
    logic [31:0] r_ssrc, n_ssrc;
    logic [17:0] r_skip, n_skip;
    logic [15:0] r_ext_type, n_ext_type;
    logic [15:0] r_ext_words, n_ext_words;
    logic [15:0] r_pcount, n_pcount;

    always_comb begin
        n_phase      = r_phase;
        n_byte_count = r_byte_count;
        n_hdr        = r_hdr;
        n_flags      = r_flags;
        n_mpt        = r_mpt;
        n_seq        = r_seq;
        n_ts         = r_ts;
        n_ssrc       = r_ssrc;
        n_skip       = r_skip;
        n_ext_type   = r_ext_type;
        n_ext_words  = r_ext_words;
        n_pcount     = r_pcount;
        o_push       = '0;

        if (i_valid && (r_byte_count < MAX_BYTES)) begin
            n_byte_count = r_byte_count + 16'd1;
            unique case (r_phase)
                PH_FIXED: begin
                    priority if (r_hdr == 5'd0) begin
                        n_flags = i_byte;
                    end else if (r_hdr == 5'd1) begin
                        n_mpt = i_byte;
                    end else if (r_hdr < 5'd4) begin
                        n_seq = {r_seq[7:0], i_byte};
                    end else if (r_hdr < 5'd8) begin
                        n_ts = {r_ts[23:0], i_byte};
                    end else begin
                        n_ssrc = {r_ssrc[23:0], i_byte};
                    end
                    n_hdr = r_hdr + 5'd1;
                    if (n_hdr >= FIXED_END) begin
                        n_skip = {12'd0, n_flags[3:0], 2'b00};
                        if (n_flags[3:0] != 4'd0) begin
                            n_phase = PH_CSRC;
                        end else begin
                            n_phase = n_flags[4] ? PH_EXTHDR : PH_PAYLOAD;
                        end
                    end
                end
                PH_CSRC: begin
                    if (r_skip != 18'd0) n_skip = r_skip - 18'd1;
                    if (n_skip == 18'd0) n_phase = r_flags[4] ? PH_EXTHDR : PH_PAYLOAD;
                end
                PH_EXTHDR: begin
                    if (r_hdr < EXT_TYPE_END) begin
                        n_ext_type = {r_ext_type[7:0], i_byte};
                    end else begin
                        n_ext_words = {r_ext_words[7:0], i_byte};
                    end
                    n_hdr = r_hdr + 5'd1;
                    if (n_hdr >= EXT_HDR_END) begin
                        // extension length counts 32-bit words
                        n_skip  = {n_ext_words, 2'b00};
                        n_phase = (n_ext_words == 16'd0) ? PH_PAYLOAD : PH_EXTBODY;
                    end
                end
                PH_EXTBODY: begin
                    if (r_skip != 18'd0) n_skip = r_skip - 18'd1;
                    if (n_skip == 18'd0) n_phase = PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                    o_push.pay_valid        = 1'b1;
                    o_push.pay.kind         = KIND_PAYLOAD;
                    o_push.pay.payload_byte = i_byte;
                    o_push.pay.last         = !i_eop;
                    n_pcount                = r_pcount + 16'd1;
                end
                default: begin
                    n_phase = PH_FIXED;
                end
            endcase
        end

        if (i_valid && i_eop) begin
            o_push.sum_valid = 1'b1;
            o_push.sum.kind  = KIND_SUMMARY;
            o_push.sum.last  = 1'b1;
            unique case (n_phase)
                PH_FIXED:   o_push.sum.status = ST_SHORT;
                PH_CSRC:    o_push.sum.status = ST_CSRC;
                PH_EXTHDR:  o_push.sum.status = ST_EXT_HDR;
                PH_EXTBODY: o_push.sum.status = ST_EXT_BODY;
                default:    o_push.sum.status = ST_OK;
            endcase
            o_push.sum.marker       = n_mpt[7];
            o_push.sum.payload_type = n_mpt[6:0];
            o_push.sum.sequence_res = n_seq;
            o_push.sum.timestamp    = n_ts;
            o_push.sum.ssrc         = n_ssrc;
            o_push.sum.version      = n_flags[7:6];
            o_push.sum.payload_len  = n_pcount;
            o_push.sum.ext_profile  = n_flags[4] ? n_ext_type : 16'd0;

            // summary closes the packet
            n_phase      = PH_FIXED;
            n_byte_count = '0;
            n_hdr        = '0;
            n_flags      = '0;
            n_mpt        = '0;
            n_seq        = '0;
            n_ts         = '0;
            n_ssrc       = '0;
            n_skip       = '0;
            n_ext_type   = '0;
            n_ext_words  = '0;
            n_pcount     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_FIXED;
            r_byte_count <= '0;
            r_hdr        <= '0;
            r_flags      <= '0;
            r_mpt        <= '0;
            r_seq        <= '0;
            r_ts         <= '0;
            r_ssrc       <= '0;
            r_skip       <= '0;
            r_ext_type   <= '0;
            r_ext_words  <= '0;
            r_pcount     <= '0;
        end else begin
            r_phase      <= n_phase;
            r_byte_count <= n_byte_count;
            r_hdr        <= n_hdr;
            r_flags      <= n_flags;
            r_mpt        <= n_mpt;
            r_seq        <= n_seq;
            r_ts         <= n_ts;
            r_ssrc       <= n_ssrc;
            r_skip       <= n_skip;
            r_ext_type   <= n_ext_type;
            r_ext_words  <= n_ext_words;
            r_pcount     <= n_pcount;
        end
    end

    `RHP_ASSERT_NEXT(a_eop_clears, i_clk, i_rst_n, i_valid && i_eop,
        r_phase == PH_FIXED && r_byte_count == 16'd0 && r_pcount == 16'd0)
    `RHP_ASSERT_NOW(a_skip_live, i_clk, i_rst_n,
        r_phase == PH_CSRC || r_phase == PH_EXTBODY, r_skip != 18'd0)

endmodule

`default_nettype wire

[src/rhp_out_fifo.sv]
// ---------------------------------------------------------------------------
// rhp_out_fifo
// Small result queue: up to two writes per cycle, one read per cycle.
// ---------------------------------------------------------------------------
`default_nettype none
`include "rtp_header_parse_payload_strip_core_assert.svh"

module rhp_out_fifo (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  rhp_pkg::t_push   i_push,
    output logic             o_room,
    output logic             o_valid,
    input  wire              i_ready,
    output rhp_pkg::t_result o_data
);
    import rhp_pkg::*;

    t_result            r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [PTR_W-1:0]   sum_ptr;
    logic               pop;

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign pop     = o_valid && i_ready;
    // room for a worst-case pair of results
    assign o_room  = (r_count <= CNT_W'(FIFO_DEPTH - 2));
    assign sum_ptr = r_wr_ptr + PTR_W'(i_push.pay_valid);

    always_comb begin
        n_wr_ptr = r_wr_ptr + PTR_W'(i_push.pay_valid) + PTR_W'(i_push.sum_valid);
        n_rd_ptr = r_rd_ptr + PTR_W'(pop);
        n_count  = r_count + CNT_W'(i_push.pay_valid) + CNT_W'(i_push.sum_valid)
                   - CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.pay_valid) r_mem[r_wr_ptr] <= i_push.pay;
        if (i_push.sum_valid) r_mem[sum_ptr]  <= i_push.sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    `RHP_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(FIFO_DEPTH))
    `RHP_ASSERT_NEXT(a_pair_push, i_clk, i_rst_n,
        i_push.pay_valid && i_push.sum_valid && !pop, r_count == $past(r_count) + CNT_W'(2))

endmodule

`default_nettype wire

[src/rtp_header_parse_payload_strip_core.sv]
// ---------------------------------------------------------------------------
// rtp_header_parse_payload_strip_core
// Byte-stream RTP header parser: forwards payload, emits a packet summary.
// ---------------------------------------------------------------------------
// Takes an RTP packet one byte per word on the slave stream, tlast on the
// final byte. The fixed 12-byte header is captured, 4*CC CSRC bytes are
// skipped, and with X set the 4-byte extension header plus 4*length body
// bytes are skipped too. Every later byte leaves at once as a payload word
// (tuser 0). The tlast byte also yields a summary word (tuser 1) carrying the
// header fields, payload length and a status naming the header part left
// unfinished. Bytes past MAX_PACKET_BYTES are dropped, though tlast on them
// still closes the packet. Throughput is one byte per cycle while the result
// queue has room; each byte passes the input register and the result queue
// on its way to the master port. A final byte that is also payload produces
// two words, and the master port moves one word per cycle. The input register
// holds its word until the four-entry result queue has room for two results.
// ---------------------------------------------------------------------------
`default_nettype none

module rtp_header_parse_payload_strip_core #(
    parameter int MAX_PACKET_BYTES = 65535
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    // slave stream
    input  wire                           s_axis_tvalid,
    output logic                          s_axis_tready,
    input  wire  [rhp_pkg::S_TDATA_W-1:0] s_axis_tdata,  // [7:0] in_byte
    input  wire                           s_axis_tlast,  // end_of_packet
    // master stream
    output logic                          m_axis_tvalid,
    input  wire                           m_axis_tready,
    // [7:0] payload_byte, [10:8] status, [11] marker, [18:12] payload_type,
    // [34:19] sequence_res, [66:35] timestamp, [98:67] ssrc, [100:99] version,
    // [116:101] payload_len, [132:117] ext_profile, [135:133] zero
    output logic [rhp_pkg::M_TDATA_W-1:0] m_axis_tdata,
    output logic                          m_axis_tlast,  // last
    output logic                          m_axis_tuser   // kind
);
    import rhp_pkg::*;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_eop;

    logic    fifo_room;
    logic    advance;
    t_push   push;
    t_result res;

    // the held word moves into the parser once the queue can take two results
    assign advance       = r_in_valid && fifo_room;
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
            r_in_eop  <= s_axis_tlast;
        end
    end

    rhp_parse #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (advance),
        .i_byte  (r_in_byte),
        .i_eop   (r_in_eop),
        .o_push  (push)
    );

    // results are registered here; the master side pops one per cycle while m_axis_tready is high
    rhp_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (fifo_room),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (res)
    );

    assign m_axis_tdata = {3'b000, res.ext_profile, res.payload_len, res.version,
                           res.ssrc, res.timestamp, res.sequence_res,
                           res.payload_type, res.marker, res.status,
                           res.payload_byte};
    assign m_axis_tlast = res.last;
    assign m_axis_tuser = res.kind;

endmodule

`default_nettype wire
